/* sv/assert_macros.svh */
// Assertion macros shared by the modular exponentiation RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, idle while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* sv/mexp_pkg.sv */
// Package for the modular exponentiation unit: widths, types, FSM states.
// Used by mexp_mulmod, mexp_seq and modular_exponentiation_unit.
package mexp_pkg;

  localparam int MOD_BITS = 32;
  localparam int EXP_BITS = 32;
  localparam int MBIT_W   = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;
  localparam int EBIT_W   = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef logic [MOD_BITS-1:0] mod_t;
  typedef logic [EXP_BITS-1:0] exp_t;
  typedef logic [MBIT_W-1:0]   mbit_t;
  typedef logic [EBIT_W-1:0]   ebit_t;

  // Request into the shared modular multiplier: x * y mod m
  typedef struct packed {
    logic start;
    mod_t x;
    mod_t y;
  } mul_req_t;

  // Response from the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
    mod_t prod;
  } mul_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } seq_state_t;

endpackage

/* sv/mexp_mulmod.sv */
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on mexp_pkg. A modulus of zero makes the product wrap at MOD_BITS.
module mexp_mulmod import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_t     modulus,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                busy;
  logic                done;
  mod_t                acc;
  mod_t                acc_next;
  mod_t                xr;
  mod_t                yr;
  mbit_t               cnt;
  logic                m_zero;
  logic [MOD_BITS:0]   dbl;
  logic [MOD_BITS:0]   sum;
  mod_t                dbl_red;
  mod_t                sum_red;

  assign m_zero = (modulus == '0);

  // One step: acc = 2*acc mod m, then add x mod m when the bit is set
  always_comb begin
    dbl = {acc, 1'b0};
    if (m_zero || dbl < {1'b0, modulus}) begin
      dbl_red = dbl[MOD_BITS-1:0];
    end else begin
      dbl_red = MOD_BITS'(dbl - {1'b0, modulus});
    end
    sum = {1'b0, dbl_red} + {1'b0, xr};
    if (m_zero || sum < {1'b0, modulus}) begin
      sum_red = sum[MOD_BITS-1:0];
    end else begin
      sum_red = MOD_BITS'(sum - {1'b0, modulus});
    end
    acc_next = yr[cnt] ? sum_red : dbl_red;
  end

  // Control: busy flag and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      acc <= '0;
      xr  <= req.x;
      yr  <= req.y;
      cnt <= mbit_t'(MOD_BITS - 1);
    end else if (busy) begin
      acc <= acc_next;
      if (cnt != '0) begin
        cnt <= cnt - mbit_t'(1);
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

/* sv/mexp_seq.sv */
// Square-and-multiply sequencer driving the shared modular multiplier.
// Depends on mexp_pkg; pairs with mexp_mulmod.
module mexp_seq import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_t     modulus,
  input  logic     in_valid,
  input  mod_t     base,
  input  exp_t     exponent,
  output logic     in_stall,
  output logic     res_valid,
  output mod_t     res_value,
  input  logic     res_ready,
  output mul_req_t mul_req,
  input  mul_rsp_t mul_rsp
);

  seq_state_t state;
  seq_state_t state_next;
  logic       launch;
  logic       launch_next;
  mod_t       base_r;
  exp_t       exp_r;
  ebit_t      ebit;
  mod_t       acc;
  logic       accept;

  assign accept = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_next  = state;
    launch_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (exponent == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next  = ST_REDUCE;
            launch_next = 1'b1;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_rsp.done) begin
          state_next  = ST_SQUARE;
          launch_next = 1'b1;
        end
      end
      ST_SQUARE: begin
        if (mul_rsp.done) begin
          if (exp_r[ebit]) begin
            state_next  = ST_MULT;
            launch_next = 1'b1;
          end else if (ebit == '0) begin
            state_next = ST_DONE;
          end else begin
            launch_next = 1'b1;
          end
        end
      end
      ST_MULT: begin
        if (mul_rsp.done) begin
          if (ebit == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next  = ST_SQUARE;
            launch_next = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall      = (state != ST_IDLE);
    res_valid     = (state == ST_DONE);
    res_value     = acc;
    mul_req.start = launch;
    unique case (state)
      ST_REDUCE: begin
        mul_req.x = mod_t'(1);
        mul_req.y = base_r;
      end
      ST_SQUARE: begin
        mul_req.x = acc;
        mul_req.y = acc;
      end
      default: begin
        mul_req.x = acc;
        mul_req.y = base_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
    end
  end

  // Operand and accumulator registers
  always_ff @(posedge clk) begin
    if (accept) begin
      base_r <= base;
      exp_r  <= exponent;
      acc    <= mod_t'(1);
    end else if (mul_rsp.done) begin
      unique case (state)
        ST_REDUCE: begin
          base_r <= mul_rsp.prod;
          acc    <= (modulus == mod_t'(1)) ? '0 : mod_t'(1);
          ebit   <= ebit_t'(EXP_BITS - 1);
        end
        ST_SQUARE: begin
          acc <= mul_rsp.prod;
          if (!exp_r[ebit] && ebit != '0) begin
            ebit <= ebit - ebit_t'(1);
          end
        end
        ST_MULT: begin
          acc <= mul_rsp.prod;
          if (ebit != '0) begin
            ebit <= ebit - ebit_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/modular_exponentiation_unit.sv */
// Top level of the modular exponentiation unit: config register, output register.
// Depends on mexp_pkg, mexp_seq, mexp_mulmod and assert_macros.svh.
//
// Computes base^exponent mod modulus by left-to-right square-and-multiply. One
// transaction at a time: in_stall stays high from acceptance until the result
// has moved into the output register. An exponent of zero returns 1. Otherwise
// the base is first reduced, then every exponent bit costs one squaring plus one
// multiply when set; each modular product runs through a single bit-serial
// multiplier at one bit per cycle. A modulus of zero gives the product wrapped
// at MOD_BITS; write the modulus only while the unit is idle.
`include "assert_macros.svh"

module modular_exponentiation_unit import mexp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic modulus_wr_en,
  input  mod_t modulus_wr_data,
  input  logic in_valid,
  output logic in_stall,
  input  mod_t base,
  input  exp_t exponent,
  output logic out_valid,
  input  logic out_stall,
  output mod_t result
);

  mod_t     modulus;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic     res_valid;
  mod_t     res_value;
  logic     res_ready;

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mod_t'(1);
    end else if (modulus_wr_en) begin
      modulus <= modulus_wr_data;
    end
  end

  mexp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .modulus   (modulus),
    .in_valid  (in_valid),
    .base      (base),
    .exponent  (exponent),
    .in_stall  (in_stall),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_ready (res_ready),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp)
  );

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (mul_req),
    .rsp     (mul_rsp)
  );

  // Output register decouples the sequencer from the result stall
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      result <= res_value;
    end
  end

  // Checks
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && !in_stall) |=> in_stall, "accepted a second transaction while busy")
  `ASSERT_CLK(a_prod_reduced, clk, rst, (mul_rsp.done && modulus != '0) |-> (mul_rsp.prod < modulus), "modular product not reduced")
  `ASSERT_NEVER(a_start_when_busy, clk, rst, mul_req.start && mul_rsp.busy, "multiplier started while busy")
  `ASSERT_CLK(a_result_loaded, clk, rst, (res_valid && res_ready) |=> out_valid, "result not captured in output register")

endmodule
